### sv/ptp_pkg.sv
// Package with the shared widths, defaults, character codes and error codes of the converter.
package ptp_pkg;

    localparam int CHAR_W = 8;
    localparam int LEN_W  = 6;
    localparam int ERR_W  = 3;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int MAX_CHARS_DEF   = 32;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;

    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 3'd1;
    localparam logic [ERR_W-1:0] ERR_FULL      = 3'd2;
    localparam logic [ERR_W-1:0] ERR_TOO_LONG  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_EMPTY     = 3'd4;

    function automatic logic is_operator(input logic [CHAR_W-1:0] c);
        is_operator = (c == CHAR_PLUS) || (c == CHAR_MINUS) ||
                      (c == CHAR_STAR) || (c == CHAR_SLASH);
    endfunction

endpackage

### sv/postfix_to_prefix_converter_top.sv
// Postfix-to-prefix converter built around a character memory and a length memory.
//
//  Channel  Direction  Handshake               Payload
//  in       request    in_valid / in_stall     symbol, end_of_expression
//  out      result     out_valid / out_stall   out_char, last_char, error_code
//
// An operand request is written in S_IDLE. An operator request passes S_OP_UP, S_OP_DN,
// S_MOVE once for each of U + D characters, and S_PUT, where U and D are the lengths of
// the two top stack entries: the character memory has one write port, so both entries
// move up one place at one character a cycle. The end of an expression passes S_END,
// S_END_LEN and S_EMIT per character, or S_END alone for an error; both wait on out_stall.
// Reset leaves the stack empty with no error latched; the memories need no clearing.
// A result waits in the output register under out_stall while the sequencer
// holds in_stall high until it can load the next result.
module postfix_to_prefix_converter_top #(
    parameter int STACK_DEPTH = ptp_pkg::STACK_DEPTH_DEF,
    parameter int MAX_CHARS   = ptp_pkg::MAX_CHARS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ptp_pkg::CHAR_W-1:0]  symbol,
    input  logic                        end_of_expression,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ptp_pkg::CHAR_W-1:0]  out_char,
    output logic                        last_char,
    output logic [ptp_pkg::ERR_W-1:0]   error_code
);
    import ptp_pkg::*;

    // Entry count and character count must be able to hold the full depth and the full character capacity.
    localparam int EC_W = $clog2(STACK_DEPTH + 1);
    localparam int CU_W = $clog2(MAX_CHARS + 1);
    localparam int LA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CA_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_OP_UP   = 8'b0000_0010,
        S_OP_DN   = 8'b0000_0100,
        S_MOVE    = 8'b0000_1000,
        S_PUT     = 8'b0001_0000,
        S_END     = 8'b0010_0000,
        S_END_LEN = 8'b0100_0000,
        S_EMIT    = 8'b1000_0000
    } state_t;

    // Stack storage: characters packed bottom to top, and one length per entry.
    logic [CHAR_W-1:0] char_mem [MAX_CHARS];
    logic [LEN_W-1:0]  len_mem  [STACK_DEPTH];
    logic [CHAR_W-1:0] char_rdata_reg;
    logic [LEN_W-1:0]  len_rdata_reg;

    logic              char_wr_en, char_rd_en, len_wr_en, len_rd_en;
    logic [CA_W-1:0]   char_wr_addr, char_rd_addr;
    logic [CHAR_W-1:0] char_wr_data;
    logic [LA_W-1:0]   len_wr_addr, len_rd_addr;
    logic [LEN_W-1:0]  len_wr_data;

    state_t            state_reg, state_next;
    logic [EC_W-1:0]   count_reg, count_next;
    logic [CU_W-1:0]   chars_reg, chars_next;
    logic [ERR_W-1:0]  err_reg, err_next;
    logic [CHAR_W-1:0] op_reg, op_next;
    logic              last_reg, last_next;
    logic [LEN_W-1:0]  upper_reg, upper_next;
    logic [CA_W-1:0]   ptr_reg, ptr_next;
    logic [CU_W-1:0]   rem_reg, rem_next;

    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              last_char_reg, last_char_next;
    logic [ERR_W-1:0]  error_code_reg, error_code_next;

    logic              in_accept, out_free;
    logic [EC_W-1:0]   count_m1, count_m2;
    logic [CU_W-1:0]   move_total, emit_start;
    logic [LEN_W:0]    merged_len;
    logic [ERR_W-1:0]  end_err;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && (state_reg == S_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign count_m1   = count_reg - EC_W'(1);
    assign count_m2   = count_reg - EC_W'(2);
    assign move_total = CU_W'(upper_reg) + CU_W'(len_rdata_reg);
    assign emit_start = chars_reg - CU_W'(len_rdata_reg);
    assign merged_len = {1'b0, upper_reg} + {1'b0, len_rdata_reg} + (LEN_W + 1)'(1);
    assign end_err    = ((err_reg == ERR_NONE) && (count_reg == '0)) ? ERR_EMPTY : err_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        chars_next      = chars_reg;
        err_next        = err_reg;
        op_next         = op_reg;
        last_next       = last_reg;
        upper_next      = upper_reg;
        ptr_next        = ptr_reg;
        rem_next        = rem_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_char_next   = out_char_reg;
        last_char_next  = last_char_reg;
        error_code_next = error_code_reg;

        char_wr_en   = 1'b0;
        char_wr_addr = ptr_reg;
        char_wr_data = char_rdata_reg;
        char_rd_en   = 1'b0;
        char_rd_addr = ptr_reg;
        len_wr_en    = 1'b0;
        len_wr_addr  = count_reg[LA_W-1:0];
        len_wr_data  = LEN_W'(1);
        len_rd_en    = 1'b0;
        len_rd_addr  = count_m1[LA_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    last_next  = end_of_expression;
                    op_next    = symbol;
                    state_next = end_of_expression ? S_END : S_IDLE;
                    if (err_reg == ERR_NONE)
                    begin
                        if (is_operator(symbol))
                        begin
                            if (count_reg < EC_W'(2))
                                err_next = ERR_UNDERFLOW;
                            else if (chars_reg >= CU_W'(MAX_CHARS))
                                err_next = ERR_TOO_LONG;
                            else
                            begin
                                len_rd_en  = 1'b1;
                                state_next = S_OP_UP;
                            end
                        end
                        else
                        begin
                            if (count_reg >= EC_W'(STACK_DEPTH))
                                err_next = ERR_FULL;
                            else if (chars_reg >= CU_W'(MAX_CHARS))
                                err_next = ERR_TOO_LONG;
                            else
                            begin
                                char_wr_en   = 1'b1;
                                char_wr_addr = chars_reg[CA_W-1:0];
                                char_wr_data = symbol;
                                len_wr_en    = 1'b1;
                                chars_next   = chars_reg + CU_W'(1);
                                count_next   = count_reg + EC_W'(1);
                            end
                        end
                    end
                end
            end
            S_OP_UP:
            begin
                upper_next  = len_rdata_reg;
                len_rd_en   = 1'b1;
                len_rd_addr = count_m2[LA_W-1:0];
                state_next  = S_OP_DN;
            end
            S_OP_DN:
            begin
                // Both entries move up one place, top character first.
                rem_next     = move_total;
                ptr_next     = chars_reg[CA_W-1:0];
                char_rd_en   = 1'b1;
                char_rd_addr = chars_reg[CA_W-1:0] - CA_W'(1);
                len_wr_data  = merged_len[LEN_W-1:0];
                upper_next   = merged_len[LEN_W-1:0];
                state_next   = S_MOVE;
            end
            S_MOVE:
            begin
                char_wr_en = 1'b1;
                ptr_next   = ptr_reg - CA_W'(1);
                rem_next   = rem_reg - CU_W'(1);
                if (rem_reg > CU_W'(1))
                begin
                    char_rd_en   = 1'b1;
                    char_rd_addr = ptr_reg - CA_W'(2);
                end
                else
                    state_next = S_PUT;
            end
            S_PUT:
            begin
                char_wr_en   = 1'b1;
                char_wr_data = op_reg;
                len_wr_en    = 1'b1;
                len_wr_addr  = count_m2[LA_W-1:0];
                len_wr_data  = upper_reg;
                chars_next   = chars_reg + CU_W'(1);
                count_next   = count_m1;
                state_next   = last_reg ? S_END : S_IDLE;
            end
            S_END:
            begin
                if (end_err != ERR_NONE)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_char_next   = '0;
                        last_char_next  = 1'b1;
                        error_code_next = end_err;
                        count_next      = '0;
                        chars_next      = '0;
                        err_next        = ERR_NONE;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    len_rd_en  = 1'b1;
                    state_next = S_END_LEN;
                end
            end
            S_END_LEN:
            begin
                if (len_rdata_reg == '0)
                begin
                    count_next = '0;
                    chars_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    rem_next     = CU_W'(len_rdata_reg);
                    ptr_next     = emit_start[CA_W-1:0];
                    char_rd_en   = 1'b1;
                    char_rd_addr = emit_start[CA_W-1:0];
                    state_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_char_next   = char_rdata_reg;
                    last_char_next  = (rem_reg == CU_W'(1));
                    error_code_next = ERR_NONE;
                    rem_next        = rem_reg - CU_W'(1);
                    if (rem_reg == CU_W'(1))
                    begin
                        count_next = '0;
                        chars_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next     = ptr_reg + CA_W'(1);
                        char_rd_en   = 1'b1;
                        char_rd_addr = ptr_reg + CA_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Synchronous memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (char_wr_en)
            char_mem[char_wr_addr] <= char_wr_data;
        if (char_rd_en)
            char_rdata_reg <= char_mem[char_rd_addr];
        if (len_wr_en)
            len_mem[len_wr_addr] <= len_wr_data;
        if (len_rd_en)
            len_rdata_reg <= len_mem[len_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            chars_reg     <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chars_reg     <= chars_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        last_reg       <= last_next;
        upper_reg      <= upper_next;
        ptr_reg        <= ptr_next;
        rem_reg        <= rem_next;
        out_char_reg   <= out_char_next;
        last_char_reg  <= last_char_next;
        error_code_reg <= error_code_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign last_char  = last_char_reg;
    assign error_code = error_code_reg;

endmodule
